[rtl/dld_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dld_pkg: shared definitions for the decimal long divider
// Widths, microcode control word, sequencer condition inputs and the
// program counter addresses of the microcode steps.
// ----------------------------------------------------------------------------
package dld_pkg;

    // Operand and result sizes.
    localparam int OPERAND_WIDTH   = 32;
    localparam int FRACTION_DIGITS = 8;
    localparam int FRAC_W          = 27;
    // Remainder register holds ten times a remainder below the divisor.
    localparam int REM_W           = OPERAND_WIDTH + 4;
    localparam int CNT_W           = $clog2((OPERAND_WIDTH > FRACTION_DIGITS) ?
                                            OPERAND_WIDTH : FRACTION_DIGITS);
    localparam int DIGIT_W         = 4;
    localparam int PC_W            = 4;

    // Program addresses of the microcode steps.
    localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] PC_CHECK = 4'd1;
    localparam logic [PC_W-1:0] PC_DIV   = 4'd2;
    localparam logic [PC_W-1:0] PC_FINIT = 4'd3;
    localparam logic [PC_W-1:0] PC_MUL   = 4'd4;
    localparam logic [PC_W-1:0] PC_SUB3  = 4'd5;
    localparam logic [PC_W-1:0] PC_SUB2  = 4'd6;
    localparam logic [PC_W-1:0] PC_SUB1  = 4'd7;
    localparam logic [PC_W-1:0] PC_SUBAC = 4'd8;
    localparam logic [PC_W-1:0] PC_EMIT  = 4'd9;

    // Datapath operations.
    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,  // take a request into the operand registers
        OP_INIT   = 3'd1,  // clear remainder, load the integer step count
        OP_DIV    = 3'd2,  // one restoring step of the integer division
        OP_FINIT  = 3'd3,  // load the fraction digit count
        OP_MUL    = 3'd4,  // remainder times ten, clear the digit
        OP_SUB    = 3'd5,  // trial subtract of the shifted divisor
        OP_SUBACC = 3'd6,  // last trial subtract, append digit to fraction
        OP_EMIT   = 3'd7   // hand the result to the output register
    } t_op;

    // Branch conditions.
    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_WAIT_IN  = 3'd1,
        C_WAIT_OUT = 3'd2,
        C_DZ       = 3'd3,
        C_CNT      = 3'd4
    } t_cond_sel;

    typedef struct packed {
        t_op              op;
        t_cond_sel        cond;
        logic [1:0]       shift;
        logic [PC_W-1:0]  target;
    } t_ctrl;

    typedef struct packed {
        logic in_fire;
        logic out_free;
        logic cnt_nz;
        logic d_zero;
    } t_cond;

endpackage

[rtl/dld_ucode_rom.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dld_ucode_rom: microcode program of the decimal long divider
// One control word per program step, read combinationally by address.
// ----------------------------------------------------------------------------
module dld_ucode_rom import dld_pkg::*; (
    input  logic [PC_W-1:0] i_pc,
    output t_ctrl           o_cw
);

    always_comb begin
        unique case (i_pc)
            PC_IDLE:  o_cw = '{op: OP_LOAD,   cond: C_WAIT_IN,  shift: 2'd0, target: PC_IDLE};
            PC_CHECK: o_cw = '{op: OP_INIT,   cond: C_DZ,       shift: 2'd0, target: PC_EMIT};
            PC_DIV:   o_cw = '{op: OP_DIV,    cond: C_CNT,      shift: 2'd0, target: PC_DIV};
            PC_FINIT: o_cw = '{op: OP_FINIT,  cond: C_NEXT,     shift: 2'd0, target: PC_IDLE};
            PC_MUL:   o_cw = '{op: OP_MUL,    cond: C_NEXT,     shift: 2'd0, target: PC_IDLE};
            PC_SUB3:  o_cw = '{op: OP_SUB,    cond: C_NEXT,     shift: 2'd3, target: PC_IDLE};
            PC_SUB2:  o_cw = '{op: OP_SUB,    cond: C_NEXT,     shift: 2'd2, target: PC_IDLE};
            PC_SUB1:  o_cw = '{op: OP_SUB,    cond: C_NEXT,     shift: 2'd1, target: PC_IDLE};
            PC_SUBAC: o_cw = '{op: OP_SUBACC, cond: C_CNT,      shift: 2'd0, target: PC_MUL};
            PC_EMIT:  o_cw = '{op: OP_EMIT,   cond: C_WAIT_OUT, shift: 2'd0, target: PC_IDLE};
            // Unused addresses act as the emit step, which then returns to idle.
            default:  o_cw = '{op: OP_EMIT,   cond: C_WAIT_OUT, shift: 2'd0, target: PC_IDLE};
        endcase
    end

endmodule

[rtl/dld_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dld_sequencer: program counter and branch logic
// Steps through the microcode, waiting or jumping on the selected condition.
// ----------------------------------------------------------------------------
module dld_sequencer import dld_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_ctrl           i_cw,
    input  t_cond           i_cond,
    output logic [PC_W-1:0] o_pc
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic [PC_W-1:0] w_inc;

    assign w_inc = r_pc + 1'b1;

    always_comb begin
        unique case (i_cw.cond)
            C_NEXT:     n_pc = w_inc;
            C_WAIT_IN:  n_pc = i_cond.in_fire  ? w_inc       : r_pc;
            C_WAIT_OUT: n_pc = i_cond.out_free ? i_cw.target : r_pc;
            C_DZ:       n_pc = i_cond.d_zero   ? i_cw.target : w_inc;
            C_CNT:      n_pc = i_cond.cnt_nz   ? i_cw.target : w_inc;
            default:    n_pc = PC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_pc = r_pc;

endmodule

[rtl/dld_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dld_datapath: operand, remainder and result registers with one subtractor
// Executes the operation named in the control word each cycle.
// ----------------------------------------------------------------------------
module dld_datapath import dld_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  t_ctrl                    i_cw,
    input  logic [OPERAND_WIDTH-1:0] i_dividend,
    input  logic [OPERAND_WIDTH-1:0] i_divisor,
    output logic                     o_cnt_nz,
    output logic                     o_d_zero,
    output logic [OPERAND_WIDTH-1:0] o_quotient,
    output logic [FRAC_W-1:0]        o_frac
);

    logic [OPERAND_WIDTH-1:0] r_q, n_q;
    logic [OPERAND_WIDTH-1:0] r_d, n_d;
    logic [REM_W-1:0]         r_r, n_r;
    logic [FRAC_W-1:0]        r_frac, n_frac;
    logic [DIGIT_W-1:0]       r_digit, n_digit;
    logic [CNT_W-1:0]         r_cnt, n_cnt;

    logic [REM_W-1:0]         w_a;
    logic [REM_W-1:0]         w_b;
    logic [REM_W:0]           w_diff;
    logic                     w_ge;
    logic [DIGIT_W-1:0]       w_last_digit;
    logic [FRAC_W+3:0]        w_frac_x10;

    // Shared subtractor: shifted remainder against divisor during the integer
    // phase, scaled remainder against a shifted divisor during the digits.
    assign w_a = (i_cw.op == OP_DIV) ?
                 {{(REM_W-OPERAND_WIDTH-1){1'b0}}, r_r[OPERAND_WIDTH-1:0], r_q[OPERAND_WIDTH-1]} :
                 r_r;
    assign w_b    = {{(REM_W-OPERAND_WIDTH){1'b0}}, r_d} << i_cw.shift;
    assign w_diff = {1'b0, w_a} - {1'b0, w_b};
    assign w_ge   = ~w_diff[REM_W];

    assign w_last_digit = {r_digit[DIGIT_W-1:1], w_ge};
    assign w_frac_x10   = ({4'd0, r_frac} << 3) + ({4'd0, r_frac} << 1) +
                          {{FRAC_W{1'b0}}, w_last_digit};

    always_comb begin
        n_q     = r_q;
        n_d     = r_d;
        n_r     = r_r;
        n_frac  = r_frac;
        n_digit = r_digit;
        n_cnt   = r_cnt;
        unique case (i_cw.op)
            OP_LOAD: begin
                if (i_load) begin
                    n_q    = i_dividend;
                    n_d    = i_divisor;
                    n_frac = '0;
                end
            end
            OP_INIT: begin
                n_r   = '0;
                n_cnt = CNT_W'(OPERAND_WIDTH - 1);
            end
            OP_DIV: begin
                n_r   = w_ge ? w_diff[REM_W-1:0] : w_a;
                n_q   = {r_q[OPERAND_WIDTH-2:0], w_ge};
                n_cnt = r_cnt - 1'b1;
            end
            OP_FINIT: begin
                n_cnt = CNT_W'(FRACTION_DIGITS - 1);
            end
            OP_MUL: begin
                n_r     = (r_r << 3) + (r_r << 1);
                n_digit = '0;
            end
            OP_SUB: begin
                if (w_ge) begin
                    n_r = w_diff[REM_W-1:0];
                end
                n_digit[i_cw.shift] = w_ge;
            end
            OP_SUBACC: begin
                if (w_ge) begin
                    n_r = w_diff[REM_W-1:0];
                end
                n_digit = w_last_digit;
                n_frac  = w_frac_x10[FRAC_W-1:0];
                n_cnt   = r_cnt - 1'b1;
            end
            OP_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q     <= n_q;
        r_d     <= n_d;
        r_r     <= n_r;
        r_frac  <= n_frac;
        r_digit <= n_digit;
        r_cnt   <= n_cnt;
    end

    assign o_cnt_nz   = |r_cnt;
    assign o_d_zero   = ~|r_d;
    assign o_quotient = r_q;
    assign o_frac     = r_frac;

`ifndef ASSERT_OFF
    // The partial remainder stays below the divisor after every integer step.
    a_div_rem_below_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cw.op == OP_DIV) |=> (r_r < {{(REM_W-OPERAND_WIDTH){1'b0}}, r_d}))
        else $error("remainder not below divisor after an integer step");

    // A digit starts from a scaled remainder below sixteen divisors.
    a_digit_range_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cw.op == OP_SUB && i_cw.shift == 2'd3) |->
        (r_r < ({{(REM_W-OPERAND_WIDTH){1'b0}}, r_d} << 4)))
        else $error("scaled remainder out of range at first digit step");

    // A finished digit is decimal and leaves a remainder below the divisor.
    a_digit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cw.op == OP_SUBACC) |=>
        (r_digit <= 4'd9 && r_r < {{(REM_W-OPERAND_WIDTH){1'b0}}, r_d}))
        else $error("digit step left an out-of-range digit or remainder");
`endif

endmodule

[rtl/decimal_long_division.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_long_division: integer quotient and eight truncated decimal digits
// Microcoded divider: a small program steers one subtractor through a
// restoring integer division and then one long-division step per digit.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Signals                      Contents (lowest bit first)
// s         in   tvalid/tready/tdata[63:0]    dividend[31:0], divisor[63:32]
// m         out  tvalid/tready/tdata[63:0]    quotient_whole[31:0],
//                + tuser[0:0]                 fraction_digits[58:32], zero pad;
//                                             tuser: divide_by_zero
//
// Each request runs from acceptance to a result in the output register
// through one check step, 32 restoring steps, one step that loads the digit
// count, five steps for each of the eight fraction digits (times ten, then
// three trial subtracts and a final subtract that appends the digit) and the
// emit step. The next request can be taken in the cycle after the emit
// step; the divider takes no new request before that.
// A zero divisor skips the arithmetic: the check step jumps to the emit step.
// Reset is synchronous and active low; it returns the program counter to
// the idle step and empties the output register.
// The output register lets a new request be taken while a result waits; a
// stalled sink only holds the sequencer at its final step.
// ----------------------------------------------------------------------------
module decimal_long_division import dld_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // dividend[31:0], divisor[63:32]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // quotient_whole[31:0], fraction_digits[58:32], zeros
    output logic [0:0]  o_m_tuser    // divide_by_zero[0]
);

    logic [PC_W-1:0]          w_pc;
    t_ctrl                    w_cw;
    t_cond                    w_cond;
    logic                     w_in_fire;
    logic                     w_out_free;
    logic                     w_emit;
    logic                     w_cnt_nz;
    logic                     w_d_zero;
    logic [OPERAND_WIDTH-1:0] w_quot;
    logic [FRAC_W-1:0]        w_frac;

    // Output register.
    logic                     r_o_valid;
    logic [OPERAND_WIDTH-1:0] r_o_quot;
    logic [FRAC_W-1:0]        r_o_frac;
    logic                     r_o_dz;

    // The idle step is the only one that waits for a request.
    assign o_s_tready = (w_cw.cond == C_WAIT_IN);
    assign w_in_fire  = i_s_tvalid & o_s_tready;
    assign w_out_free = ~r_o_valid | i_m_tready;
    assign w_emit     = (w_cw.op == OP_EMIT) & w_out_free;

    assign w_cond = '{in_fire: w_in_fire, out_free: w_out_free,
                      cnt_nz: w_cnt_nz, d_zero: w_d_zero};

    dld_ucode_rom u_rom (
        .i_pc (w_pc),
        .o_cw (w_cw)
    );

    dld_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cw    (w_cw),
        .i_cond  (w_cond),
        .o_pc    (w_pc)
    );

    dld_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_in_fire),
        .i_cw       (w_cw),
        .i_dividend (i_s_tdata[OPERAND_WIDTH-1:0]),
        .i_divisor  (i_s_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH]),
        .o_cnt_nz   (w_cnt_nz),
        .o_d_zero   (w_d_zero),
        .o_quotient (w_quot),
        .o_frac     (w_frac)
    );

    // A zero divisor reports zero in both result fields.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_quot <= w_d_zero ? '0 : w_quot;
            r_o_frac <= w_d_zero ? '0 : w_frac;
            r_o_dz   <= w_d_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_emit) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {{(64-OPERAND_WIDTH-FRAC_W){1'b0}}, r_o_frac, r_o_quot};
    assign o_m_tuser  = r_o_dz;

`ifndef ASSERT_OFF
    // A divide-by-zero result carries zero in both data fields.
    a_dz_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == 64'd0))
        else $error("divide-by-zero result with non-zero payload");

    // An accepted request always moves the program on to the divisor check.
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (w_pc == PC_CHECK))
        else $error("sequencer did not leave idle after a request");

    // Requests are taken only at the idle step.
    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (w_pc == PC_IDLE))
        else $error("input ready outside the idle step");

    // A result handed over always appears at the output.
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> o_m_tvalid)
        else $error("finished result did not reach the output register");
`endif

endmodule
